FILE: rtl/modbus_read_response_checker_assert.svh
// Assertion macros for the Modbus read response checker.
// Included by the files that carry concurrent checks; no other dependency.
`ifndef MODBUS_READ_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_READ_RESPONSE_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define MRRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// Next-cycle implication, disabled while reset is low.
`define MRRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define MRRC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MRRC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/mrrc_pkg.sv
// Shared types and constants for the Modbus read response checker.
// No dependencies; used by the top level, the response monitor and the testbench.
package mrrc_pkg;

    localparam int MAX_REGS_DEF = 32;

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FRAME_OVERHEAD    = 8'd5;

    // Configuration register indexes
    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_REG_COUNT  = 1'b1;

    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_last;
    } t_in_item;

    typedef struct packed {
        logic        frame_ok;
        logic [4:0]  reg_index;
        logic [15:0] reg_value;
        logic        run_last;
    } t_out_item;

endpackage

FILE: rtl/mrrc_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic storage for the checker; no package dependency.
module mrrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/modbus_read_response_checker.sv
// Modbus RTU read-holding-registers response checker. Bytes of a response
// frame enter one item at a time, the last flagged. The CRC-16 runs two bytes
// behind the input through a bit-serial unit that shifts one bit per cycle,
// so the first two bytes of a frame are accepted without shifting and each
// later byte is accepted, then shifted through; o_in_stall is high meanwhile.
// After the last byte a decision state follows; a rejected frame yields one
// failure item, an accepted frame yields its registers one by one through
// read and emit states (registered store read). Input stays stalled until
// the last result is loaded into the output register. Configuration is taken
// by plain writes at any time but is meant to change only while idle.
`include "modbus_read_response_checker_assert.svh"

module modbus_read_response_checker #(
    parameter int MAX_REGS = mrrc_pkg::MAX_REGS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mrrc_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mrrc_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [mrrc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import mrrc_pkg::*;

    localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam logic [6:0] MAX_REGS_V = 7'(MAX_REGS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CRC    = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_RD     = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_bit, n_bit;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_pos, n_pos;
    logic        r_hdr_good, n_hdr_good;
    logic [7:0]  r_lag0, n_lag0;
    logic [7:0]  r_lag1, n_lag1;
    logic [7:0]  r_hold, n_hold;
    logic [15:0] r_crc_recv, n_crc_recv;
    logic        r_last_pend, n_last_pend;
    logic [5:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_data, n_out_data;
    logic [7:0]  r_slave_addr, n_slave_addr;
    logic [5:0]  r_reg_count, n_reg_count;

    logic          in_acc;
    logic          out_free;
    logic [7:0]    data_off;
    logic [6:0]    word_idx;
    logic          ram_we;
    logic [15:0]   ram_rdata;
    logic          frame_ok;
    logic          emit_last;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign data_off = r_pos - 8'd3;
    assign word_idx = data_off[7:1];
    assign ram_we   = in_acc && (r_pos >= 8'd3) && !data_off[0] ? 1'b0 :
                      in_acc && (r_pos >= 8'd3) && data_off[0] && (word_idx < MAX_REGS_V);

    assign frame_ok = r_hdr_good
                   && (r_reg_count != 6'd0)
                   && ({1'b0, r_reg_count} <= MAX_REGS_V)
                   && (r_pos == FRAME_OVERHEAD + {1'b0, r_reg_count, 1'b0})
                   && (r_crc == r_crc_recv);

    assign emit_last = (r_idx == r_reg_count - 6'd1);

    mrrc_ram #(
        .WIDTH (16),
        .DEPTH (MAX_REGS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (word_idx[AW-1:0]),
        .i_wdata ({r_hold, i_in_data.rx_byte}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_bit        = r_bit;
        n_crc        = r_crc;
        n_pos        = r_pos;
        n_hdr_good   = r_hdr_good;
        n_lag0       = r_lag0;
        n_lag1       = r_lag1;
        n_hold       = r_hold;
        n_crc_recv   = r_crc_recv;
        n_last_pend  = r_last_pend;
        n_idx        = r_idx;
        n_out_data   = r_out_data;
        n_slave_addr = r_slave_addr;
        n_reg_count  = r_reg_count;
        n_out_valid  = r_out_valid && i_out_stall;

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SLAVE_ADDR) begin
                n_slave_addr = i_cfg_data;
            end else begin
                n_reg_count = i_cfg_data[5:0];
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    // header checks
                    if (r_pos == 8'd0 && i_in_data.rx_byte != r_slave_addr) begin
                        n_hdr_good = 1'b0;
                    end
                    if (r_pos == 8'd1 && i_in_data.rx_byte != FUNC_READ_HOLDING) begin
                        n_hdr_good = 1'b0;
                    end
                    if (r_pos == 8'd2 && i_in_data.rx_byte != {1'b0, r_reg_count, 1'b0}) begin
                        n_hdr_good = 1'b0;
                    end
                    // hold the high byte of a data word
                    if (r_pos >= 8'd3 && !data_off[0]) begin
                        n_hold = i_in_data.rx_byte;
                    end
                    n_crc_recv  = {i_in_data.rx_byte, r_lag0};
                    n_lag1      = r_lag0;
                    n_lag0      = i_in_data.rx_byte;
                    n_pos       = (r_pos == 8'hFF) ? r_pos : r_pos + 8'd1;
                    n_last_pend = i_in_data.frame_last;
                    if (r_pos >= 8'd2) begin
                        // feed the byte two behind, then shift it through
                        n_crc   = r_crc ^ {8'h00, r_lag1};
                        n_bit   = 3'd0;
                        n_state = ST_CRC;
                    end else if (i_in_data.frame_last) begin
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_CRC: begin
                n_crc = r_crc[0] ? ((r_crc >> 1) ^ CRC_POLY) : (r_crc >> 1);
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_state = r_last_pend ? ST_DECIDE : ST_IDLE;
                end
            end
            ST_DECIDE: begin
                n_idx = 6'd0;
                if (frame_ok || out_free) begin
                    // rearm the frame state
                    n_crc      = CRC_INIT;
                    n_pos      = 8'd0;
                    n_hdr_good = 1'b1;
                    n_lag0     = 8'd0;
                    n_lag1     = 8'd0;
                    n_hold     = 8'd0;
                    if (frame_ok) begin
                        n_state = ST_RD;
                    end else begin
                        n_out_valid          = 1'b1;
                        n_out_data.frame_ok  = 1'b0;
                        n_out_data.reg_index = 5'd0;
                        n_out_data.reg_value = 16'd0;
                        n_out_data.run_last  = 1'b1;
                        n_state              = ST_IDLE;
                    end
                end
            end
            ST_RD: begin
                // read address is r_idx; data shows up next cycle
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_data.frame_ok  = 1'b1;
                    n_out_data.reg_index = r_idx[4:0];
                    n_out_data.reg_value = ram_rdata;
                    n_out_data.run_last  = emit_last;
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 6'd1;
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_bit        <= 3'd0;
            r_crc        <= CRC_INIT;
            r_pos        <= 8'd0;
            r_hdr_good   <= 1'b1;
            r_lag0       <= 8'd0;
            r_lag1       <= 8'd0;
            r_hold       <= 8'd0;
            r_last_pend  <= 1'b0;
            r_idx        <= 6'd0;
            r_out_valid  <= 1'b0;
            r_slave_addr <= 8'd1;
            r_reg_count  <= 6'd1;
        end else begin
            r_state      <= n_state;
            r_bit        <= n_bit;
            r_crc        <= n_crc;
            r_pos        <= n_pos;
            r_hdr_good   <= n_hdr_good;
            r_lag0       <= n_lag0;
            r_lag1       <= n_lag1;
            r_hold       <= n_hold;
            r_last_pend  <= n_last_pend;
            r_idx        <= n_idx;
            r_out_valid  <= n_out_valid;
            r_slave_addr <= n_slave_addr;
            r_reg_count  <= n_reg_count;
        end
        r_crc_recv <= n_crc_recv;
        r_out_data <= n_out_data;
    end

    `MRRC_ASSERT_IMP(a_fail_is_single, i_clk, i_rst_n, r_out_valid && !r_out_data.frame_ok, r_out_data.run_last && (r_out_data.reg_value == 16'd0))
    `MRRC_ASSERT_NXT(a_crc_follows, i_clk, i_rst_n, in_acc && (r_pos >= 8'd2), r_state == ST_CRC)
    `MRRC_ASSERT_NXT(a_run_ends_idle, i_clk, i_rst_n, (r_state == ST_EMIT) && out_free && emit_last, (r_state == ST_IDLE) && r_out_valid && r_out_data.run_last)

endmodule

FILE: tb/modbus_response_monitor.sv
// Watch-side checker for the Modbus read response checker: tracks config
// writes, predicts each frame's results and compares them item by item.
// Depends on mrrc_pkg for the item types, codes and frame constants.
`timescale 1ns / 100ps

module modbus_response_monitor #(
    parameter int MAX_REGS = mrrc_pkg::MAX_REGS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  mrrc_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  mrrc_pkg::t_out_item             i_out_data,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [mrrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import mrrc_pkg::*;

    logic [7:0]  slave_addr_q;
    logic [5:0]  reg_count_q;
    logic [15:0] crc_q;
    logic [7:0]  pos_q;
    logic        header_ok_q;
    logic [7:0]  lag_q [2];
    logic [7:0]  high_q;
    logic [15:0] word_store_q [MAX_REGS];

    t_out_item expected_regs_q [$];
    int        fails;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fails        = 0;
    end

    function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
        int k;
        c = c ^ {8'h00, b};
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic rearm_frame();
        crc_q       = CRC_INIT;
        pos_q       = '0;
        header_ok_q = 1'b1;
        lag_q[0]    = '0;
        lag_q[1]    = '0;
        high_q      = '0;
    endtask

    // Advance the frame state by one byte; on the last byte queue the results.
    task automatic absorb_frame_byte(t_in_item it);
        int          p;
        int          off;
        int          i;
        logic [15:0] crc_rx;
        logic        ok;
        t_out_item   r;
        p = int'(pos_q);
        if (p == 0 && it.rx_byte != slave_addr_q) header_ok_q = 1'b0;
        if (p == 1 && it.rx_byte != FUNC_READ_HOLDING) header_ok_q = 1'b0;
        if (p == 2 && it.rx_byte != {1'b0, reg_count_q, 1'b0}) header_ok_q = 1'b0;
        if (p >= 3) begin
            off = p - 3;
            if (off % 2 == 0) begin
                high_q = it.rx_byte;
            end else if (off / 2 < MAX_REGS) begin
                word_store_q[off / 2] = {high_q, it.rx_byte};
            end
        end
        // CRC lags the input by two bytes; the newest two are the received CRC
        if (p >= 2) crc_q = crc16_byte(crc_q, lag_q[1]);
        crc_rx   = {it.rx_byte, lag_q[0]};
        lag_q[1] = lag_q[0];
        lag_q[0] = it.rx_byte;
        if (pos_q != 8'hFF) pos_q = pos_q + 8'd1;
        if (!it.frame_last) return;

        ok = header_ok_q && reg_count_q >= 1 && int'(reg_count_q) <= MAX_REGS
            && p + 1 == int'(FRAME_OVERHEAD) + 2 * int'(reg_count_q)
            && crc_q == crc_rx;
        rearm_frame();
        if (!ok) begin
            r          = '0;
            r.run_last = 1'b1;
            expected_regs_q.push_back(r);
        end else begin
            for (i = 0; i < int'(reg_count_q); i++) begin
                r.frame_ok  = 1'b1;
                r.reg_index = 5'(i);
                r.reg_value = word_store_q[i];
                r.run_last  = (i == int'(reg_count_q) - 1);
                expected_regs_q.push_back(r);
            end
        end
    endtask

    task automatic compare_result(t_out_item got);
        t_out_item want;
        if (expected_regs_q.size() == 0) begin
            $error("unexpected result: frame_ok=%0d reg_index=%0d reg_value=%h run_last=%0d",
                   got.frame_ok, got.reg_index, got.reg_value, got.run_last);
            fails++;
            return;
        end
        want = expected_regs_q.pop_front();
        if (got.frame_ok !== want.frame_ok) begin
            $error("frame_ok: expected %0d, got %0d", want.frame_ok, got.frame_ok);
            fails++;
        end
        if (got.reg_index !== want.reg_index) begin
            $error("reg_index: expected %0d, got %0d", want.reg_index, got.reg_index);
            fails++;
        end
        if (got.reg_value !== want.reg_value) begin
            $error("reg_value: expected %h, got %h", want.reg_value, got.reg_value);
            fails++;
        end
        if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slave_addr_q = 8'd1;
            reg_count_q  = 6'd1;
            rearm_frame();
            expected_regs_q.delete();
        end else begin
            // Compare first so a result can never match its own frame's byte
            if (i_out_valid && !i_out_stall) compare_result(i_out_data);
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SLAVE_ADDR) begin
                    slave_addr_q = i_cfg_data;
                end else begin
                    reg_count_q = i_cfg_data[5:0];
                end
            end
            if (i_in_valid && !i_in_stall) absorb_frame_byte(i_in_data);
        end
        o_fail_count <= fails;
        o_pending    <= expected_regs_q.size();
    end

endmodule

FILE: tb/tb.sv
// Top of the Modbus read response checker testbench: clock, reset, frame
// stimulus, receiver stalls and verdict. Depends on mrrc_pkg, the block
// and modbus_response_monitor, which does all prediction and comparison.
`timescale 1ns / 100ps

module tb;
    import mrrc_pkg::*;

    typedef enum int {
        FR_GOOD,
        FR_BAD_ADDR,
        FR_BAD_FUNC,
        FR_BAD_COUNT,
        FR_BAD_CRC,
        FR_SHORT,
        FR_LONG,
        FR_NOISE
    } t_frame_kind;

    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 260;
    localparam int LONG_HOLD     = 400;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;
    logic       cfg_we = 1'b0;
    logic       cfg_idx = CFG_SLAVE_ADDR;
    logic [7:0] cfg_data = '0;
    int         fail_count;
    int         pending;

    logic [7:0] frame_q [$];
    int         frame_addr = 1;
    int         frame_count = 1;
    bit         tx_burst = 1'b0;
    bit         rx_burst = 1'b0;
    int         hold_len = 0;
    int         random_items = 0;

    always #5 i_clk = ~i_clk;

    modbus_read_response_checker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    modbus_response_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Append the CRC over the whole queue, low byte first.
    task automatic seal_frame();
        logic [15:0] c;
        int          k;
        c = CRC_INIT;
        foreach (frame_q[i]) begin
            c = c ^ {8'h00, frame_q[i]};
            for (k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endtask

    task automatic build_frame(t_frame_kind kind);
        int n;
        frame_q.delete();
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 10)) frame_q.push_back(rand_byte());
            return;
        end
        frame_q.push_back(8'(frame_addr));
        frame_q.push_back(FUNC_READ_HOLDING);
        frame_q.push_back(8'(2 * frame_count));
        repeat (2 * frame_count) frame_q.push_back(rand_byte());
        case (kind)
            FR_BAD_ADDR:  frame_q[0] = frame_q[0] ^ 8'($urandom_range(1, 255));
            FR_BAD_FUNC:  frame_q[1] = frame_q[1] ^ 8'($urandom_range(1, 255));
            FR_BAD_COUNT: frame_q[2] = frame_q[2] ^ 8'($urandom_range(1, 255));
            FR_LONG:      repeat ($urandom_range(1, 4)) frame_q.push_back(rand_byte());
            default:      ;
        endcase
        seal_frame();
        if (kind == FR_BAD_CRC) begin
            n = frame_q.size() - 1 - $urandom_range(0, 1);
            frame_q[n] = frame_q[n] ^ 8'($urandom_range(1, 255));
        end
        if (kind == FR_SHORT) begin
            n = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > n) void'(frame_q.pop_back());
        end
    endtask

    // Offer one item after a drawn gap; valid stays high on return.
    task automatic send_item(logic [7:0] b, logic last);
        int       gap;
        t_in_item it;
        it.rx_byte    = b;
        it.frame_last = last;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic send_frame();
        tx_burst = ($urandom_range(0, 4) == 0);
        foreach (frame_q[i]) send_item(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [7:0] addr, logic [7:0] count_raw);
        frame_addr  = addr;
        frame_count = count_raw[5:0];
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SLAVE_ADDR;
        cfg_data <= addr;
        @(posedge i_clk);
        cfg_idx  <= CFG_REG_COUNT;
        cfg_data <= count_raw;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: per result a drawn stall, or a long hold when one is requested.
    initial begin
        int n;
        int served;
        served = 0;
        forever begin
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
            end else begin
                n = rx_burst ? 0 : $urandom_range(0, 11);
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
            served++;
            if (served % 16 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int          phase;
        int          frames;
        int          r;
        int          count6;
        logic [7:0]  addr;
        t_frame_kind kind;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset config: address 1, one register
        frame_q = '{8'h01, 8'h03, 8'h02, 8'hFF, 8'h00};
        seal_frame();
        send_frame();
        frame_q = '{8'h00};
        send_frame();
        frame_q = '{8'h01, 8'h04, 8'h02, 8'h00, 8'hFF};
        seal_frame();
        send_frame();
        frame_q = '{8'h01, 8'h03, 8'h02, 8'h12, 8'h34};
        seal_frame();
        frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ 8'h80;
        send_frame();
        frame_q = '{8'hFF, 8'h03};
        send_frame();
        wait_idle();

        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            addr = rand_byte();
            case (phase)
                0: begin addr = 8'h00; count6 = 32; end
                1: begin addr = 8'hFF; count6 = 1; end
                2: count6 = 0;
                3: count6 = 40;
                default: begin
                    r = $urandom_range(0, 9);
                    if (r == 0) count6 = 32;
                    else if (r == 1) count6 = $urandom_range(5, 16);
                    else if (r == 2) count6 = $urandom_range(33, 63);
                    else count6 = $urandom_range(1, 4);
                end
            endcase
            set_config(addr, {2'($urandom_range(0, 3)), 6'(count6)});
            // Hold the receiver while frames keep coming so the block backs up
            if (phase == 1) hold_len = LONG_HOLD;
            frames = (count6 > 8) ? 1 : $urandom_range(3, 8);
            repeat (frames) begin
                r = $urandom_range(0, 19);
                kind = (r <= 6) ? t_frame_kind'(r + 1) : FR_GOOD;
                if (phase < 2) kind = FR_GOOD;
                build_frame(kind);
                send_frame();
                random_items += frame_q.size();
                if ($urandom_range(0, 7) == 0) wait_idle();
            end
            wait_idle();
            phase++;
        end

        // Run past the position counter's saturation with a sound header and CRC
        set_config(rand_byte(), 8'd1);
        build_frame(FR_GOOD);
        void'(frame_q.pop_back());
        void'(frame_q.pop_back());
        repeat (256) frame_q.push_back(rand_byte());
        seal_frame();
        send_frame();
        build_frame(FR_GOOD);
        send_frame();
        wait_idle();

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
